@@ src/plqhc_pkg.sv @@
// Shared types and constants for the per-layer quota handle cache.
// No dependencies.
`timescale 1ns / 1ps
package plqhc_pkg;

   localparam int STAMP_W  = 64;
   localparam int HANDLE_W = 32;
   localparam int LAYER_W  = 3;
   localparam int LIMIT_W  = 4;
   localparam int LFSR_W   = 16;
   localparam int COUNT_W  = 4;
   localparam int MAX_RESULTS = 64;
   localparam int EMIT_W   = $clog2(MAX_RESULTS + 1);

   localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'hACE1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_ERASE  = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   localparam logic RES_ANSWER = 1'b0;
   localparam logic RES_CLOSE  = 1'b1;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [LAYER_W-1:0]  layer;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MISS,
      ST_DIV,
      ST_RANK,
      ST_EVICT,
      ST_DROP
   } state_type;

endpackage

@@ src/per_layer_quota_handle_cache.sv @@
// Top level of the per-layer quota handle cache: sequencer, entry scanner, CSR.
// Depends on plqhc_pkg, plqhc_mem and plqhc_rem.
//
//   channel   ports                     handshake
//   request   req_* fields              start, busy
//   result    rsp_* fields              rsp_valid strobe, one cycle
//   csr       psel/penable/pwrite/...   APB, pready tied high
//
// Lookup, erase and clear walk the entry store one entry per cycle through its read port.
// Lookup: one search pass, cut short on a hit; each eviction adds a run of the
// remainder unit plus (rank+1) further passes over the store.
// Erase/clear: one pass per dropped entry plus a final empty pass.
// Synchronous reset clears valid bits and layer counts, presets LFSR and limit; no clearing pass.
// Results are strobed for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
module per_layer_quota_handle_cache #(
   parameter int ENTRIES = 64,
   parameter int LAYERS  = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_kind,
   input  logic [plqhc_pkg::STAMP_W-1:0]     req_stamp,
   input  logic [plqhc_pkg::LAYER_W-1:0]     req_layer,
   input  logic [plqhc_pkg::HANDLE_W-1:0]    req_fresh_handle,
   input  logic                              req_fresh_ok,
   output logic                              rsp_valid,
   output logic                              rsp_result_kind,
   output logic [plqhc_pkg::HANDLE_W-1:0]    rsp_handle,
   output logic                              rsp_hit,
   output logic                              rsp_last,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [1:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import plqhc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   function automatic logic [LAYER_W-1:0] layer_mod(input logic [LAYER_W-1:0] l);
      logic [LAYER_W-1:0] v;
      v = l;
      for (int k = 0; k < 8; k++) begin
         if (int'(v) >= LAYERS) begin
            v = v - LAYER_W'(LAYERS);
         end
      end
      return v;
   endfunction

   state_type state_ff, state_in;

   // item
   logic                 all_ff, all_in;
   logic [STAMP_W-1:0]   stamp_ff, stamp_in;
   logic [LAYER_W-1:0]   lidx_ff, lidx_in;
   logic [HANDLE_W-1:0]  fresh_ff, fresh_in;
   logic                 ok_ff, ok_in;

   logic [LIMIT_W-1:0]   limit_ff;
   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in, lfsr_next;
   logic                 valid_ff [ENTRIES];
   logic [COUNT_W-1:0]   count_ff [LAYERS];

   // scanner
   logic                 iss_ff, iss_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 pass_start, pass_kill, pass_end;

   // running minimum of a pass
   logic                 best_found_ff, best_found_in, best_found_n;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in, best_idx_n;
   logic [STAMP_W-1:0]   best_stamp_ff, best_stamp_in, best_stamp_n;
   logic [HANDLE_W-1:0]  best_handle_ff, best_handle_in, best_handle_n;
   logic                 thr_en_ff, thr_en_in;
   logic [STAMP_W-1:0]   thr_ff, thr_in;

   logic                 free_found_ff, free_found_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic [COUNT_W-1:0]   rank_ff, rank_in;
   logic                 hold_ff, hold_in;
   logic [HANDLE_W-1:0]  hold_handle_ff, hold_handle_in;
   logic [EMIT_W-1:0]    emit_cnt_ff, emit_cnt_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [HANDLE_W-1:0]  rsp_handle_ff, rsp_handle_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   logic                 rsp_last_ff, rsp_last_in;

   // store and count updates
   logic                 v_clr, v_set, c_dec, c_inc, c_zero, c_zero_all;
   logic [IDX_W-1:0]     v_clr_idx;

   entry_type            rd_data, wr_data;
   logic                 cur_valid, cand, take, hit_now;
   logic [LW-1:0]        cidx;
   logic [COUNT_W-1:0]   cur_count, eff_limit;
   logic                 div_start, div_done;
   logic [COUNT_W-1:0]   div_rem;
   logic                 accept, csr_write;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   // the only register reads back at offset 0; a write at any offset reaches it
   assign prdata    = (paddr == 2'd0) ? {{(32 - LIMIT_W){1'b0}}, limit_ff} : '0;

   assign cidx      = LW'(lidx_ff);
   assign cur_count = count_ff[cidx];
   assign eff_limit = (limit_ff == '0) ? COUNT_W'(1) : limit_ff;
   assign lfsr_next = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[LFSR_W-1:1]};

   assign cur_valid = valid_ff[rd_idx_ff];
   assign pass_end  = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign hit_now   = rd_vld_ff && cur_valid && (rd_data.stamp == stamp_ff);
   assign cand      = rd_vld_ff && cur_valid && (all_ff || rd_data.layer == lidx_ff) &&
                      (!thr_en_ff || rd_data.stamp > thr_ff);
   assign take      = cand && (!best_found_ff || rd_data.stamp < best_stamp_ff);

   assign best_found_n  = best_found_ff || take;
   assign best_idx_n    = take ? rd_idx_ff : best_idx_ff;
   assign best_stamp_n  = take ? rd_data.stamp : best_stamp_ff;
   assign best_handle_n = take ? rd_data.handle : best_handle_ff;

   assign wr_data.stamp  = stamp_ff;
   assign wr_data.layer  = lidx_ff;
   assign wr_data.handle = fresh_ff;

   plqhc_mem #(
      .DEPTH (ENTRIES),
      .AW    (IDX_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (v_set),
      .wr_addr (free_idx_ff),
      .wr_data (wr_data),
      .rd_en   (iss_ff),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   plqhc_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lfsr_next),
      .divisor  (cur_count),
      .done     (div_done),
      .rem      (div_rem)
   );

   always_comb begin
      state_in       = state_ff;
      all_in         = all_ff;
      stamp_in       = stamp_ff;
      lidx_in        = lidx_ff;
      fresh_in       = fresh_ff;
      ok_in          = ok_ff;
      lfsr_in        = lfsr_ff;
      thr_en_in      = thr_en_ff;
      thr_in         = thr_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      rank_in        = rank_ff;
      hold_in        = hold_ff;
      hold_handle_in = hold_handle_ff;
      emit_cnt_in    = emit_cnt_ff;
      rsp_valid_in   = 1'b0;
      rsp_kind_in    = RES_ANSWER;
      rsp_handle_in  = '0;
      rsp_hit_in     = 1'b0;
      rsp_last_in    = 1'b0;
      pass_start     = 1'b0;
      pass_kill      = 1'b0;
      div_start      = 1'b0;
      v_clr          = 1'b0;
      v_clr_idx      = best_idx_ff;
      v_set          = 1'b0;
      c_dec          = 1'b0;
      c_inc          = 1'b0;
      c_zero         = 1'b0;
      c_zero_all     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               stamp_in      = req_stamp;
               lidx_in       = layer_mod(req_layer);
               fresh_in      = req_fresh_handle;
               ok_in         = req_fresh_ok;
               thr_en_in     = 1'b0;
               free_found_in = 1'b0;
               hold_in       = 1'b0;
               emit_cnt_in   = '0;
               all_in        = (req_kind == KIND_CLEAR);
               case (req_kind)
                  KIND_LOOKUP: begin
                     all_in     = 1'b0;
                     pass_start = 1'b1;
                     state_in   = ST_SEARCH;
                  end
                  KIND_ERASE, KIND_CLEAR: begin
                     pass_start = 1'b1;
                     state_in   = ST_DROP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SEARCH: begin
            if (rd_vld_ff && !cur_valid) begin
               free_found_in = 1'b1;
               free_idx_in   = rd_idx_ff;
            end
            if (hit_now) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = rd_data.handle;
               rsp_hit_in    = 1'b1;
               rsp_last_in   = 1'b1;
               pass_kill     = 1'b1;
               state_in      = ST_IDLE;
            end else if (pass_end) begin
               if (ok_ff) begin
                  state_in = ST_MISS;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         ST_MISS: begin
            if (cur_count >= eff_limit) begin
               lfsr_in   = lfsr_next;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               if (free_found_ff) begin
                  v_set = 1'b1;
                  c_inc = 1'b1;
               end
               rsp_valid_in  = 1'b1;
               rsp_handle_in = fresh_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rank_in    = div_rem;
               thr_en_in  = 1'b0;
               pass_start = 1'b1;
               state_in   = ST_RANK;
            end
         end
         ST_RANK: begin
            // rank k: k+1 passes, each finding the smallest stamp above the last
            if (pass_end) begin
               if (rank_ff == '0) begin
                  state_in = ST_EVICT;
               end else begin
                  rank_in    = rank_ff - 1'b1;
                  thr_in     = best_stamp_n;
                  thr_en_in  = 1'b1;
                  pass_start = 1'b1;
               end
            end
         end
         ST_EVICT: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = RES_CLOSE;
            rsp_handle_in = best_handle_ff;
            v_clr         = 1'b1;
            c_dec         = 1'b1;
            free_found_in = 1'b1;
            free_idx_in   = best_idx_ff;
            state_in      = ST_MISS;
         end
         ST_DROP: begin
            // one handle held back so the final one can carry last
            if (pass_end) begin
               if (best_found_n) begin
                  if (hold_ff && emit_cnt_ff < EMIT_W'(MAX_RESULTS)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = RES_CLOSE;
                     rsp_handle_in = hold_handle_ff;
                     rsp_last_in   = (emit_cnt_ff == EMIT_W'(MAX_RESULTS - 1));
                     emit_cnt_in   = emit_cnt_ff + 1'b1;
                  end
                  hold_in        = 1'b1;
                  hold_handle_in = best_handle_n;
                  v_clr          = 1'b1;
                  v_clr_idx      = best_idx_n;
                  pass_start     = 1'b1;
               end else begin
                  if (hold_ff && emit_cnt_ff < EMIT_W'(MAX_RESULTS)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = RES_CLOSE;
                     rsp_handle_in = hold_handle_ff;
                     rsp_last_in   = 1'b1;
                  end
                  c_zero     = !all_ff;
                  c_zero_all = all_ff;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // scanner and pass minimum
   always_comb begin
      iss_in         = iss_ff;
      idx_in         = idx_ff;
      best_found_in  = best_found_n;
      best_idx_in    = best_idx_n;
      best_stamp_in  = best_stamp_n;
      best_handle_in = best_handle_n;
      if (pass_start) begin
         iss_in        = 1'b1;
         idx_in        = '0;
         best_found_in = 1'b0;
      end else if (iss_ff) begin
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX) begin
            iss_in = 1'b0;
         end
      end
      if (pass_kill) begin
         iss_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iss_ff       <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         lfsr_ff      <= LFSR_SEED;
         for (int i = 0; i < ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
         for (int l = 0; l < LAYERS; l++) begin
            count_ff[l] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         rd_vld_ff    <= iss_ff;
         rsp_valid_ff <= rsp_valid_in;
         lfsr_ff      <= lfsr_in;
         if (csr_write) begin
            limit_ff <= pwdata[LIMIT_W-1:0];
         end
         if (v_clr) begin
            valid_ff[v_clr_idx] <= 1'b0;
         end
         if (v_set) begin
            valid_ff[free_idx_ff] <= 1'b1;
         end
         if (c_zero_all) begin
            for (int l = 0; l < LAYERS; l++) begin
               count_ff[l] <= '0;
            end
         end else if (c_zero) begin
            count_ff[cidx] <= '0;
         end else if (c_dec) begin
            count_ff[cidx] <= cur_count - 1'b1;
         end else if (c_inc) begin
            count_ff[cidx] <= cur_count + 1'b1;
         end
      end
      idx_ff         <= idx_in;
      rd_idx_ff      <= idx_ff;
      all_ff         <= all_in;
      stamp_ff       <= stamp_in;
      lidx_ff        <= lidx_in;
      fresh_ff       <= fresh_in;
      ok_ff          <= ok_in;
      best_found_ff  <= best_found_in;
      best_idx_ff    <= best_idx_in;
      best_stamp_ff  <= best_stamp_in;
      best_handle_ff <= best_handle_in;
      thr_en_ff      <= thr_en_in;
      thr_ff         <= thr_in;
      free_found_ff  <= free_found_in;
      free_idx_ff    <= free_idx_in;
      rank_ff        <= rank_in;
      hold_ff        <= hold_in;
      hold_handle_ff <= hold_handle_in;
      emit_cnt_ff    <= emit_cnt_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_handle      = rsp_handle_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ src/plqhc_mem.sv @@
// Entry store: one write port, one registered read port.
// Depends on plqhc_pkg.
`timescale 1ns / 1ps
module plqhc_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  plqhc_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output plqhc_pkg::entry_type rd_data
);
   import plqhc_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/plqhc_rem.sv @@
// Bit-serial remainder unit: LFSR value modulo a layer's entry count.
// Depends on plqhc_pkg.
`timescale 1ns / 1ps
module plqhc_rem (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [plqhc_pkg::LFSR_W-1:0]   dividend,
   input  logic [plqhc_pkg::COUNT_W-1:0]  divisor,
   output logic                           done,
   output logic [plqhc_pkg::COUNT_W-1:0]  rem
);
   import plqhc_pkg::*;

   localparam int STEP_W = $clog2(LFSR_W);

   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [LFSR_W-1:0]   sh_ff, sh_in;
   logic [COUNT_W-1:0]  div_ff, div_in;
   logic [COUNT_W-1:0]  r_ff, r_in;
   logic [COUNT_W:0]    trial;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sh_in   = sh_ff;
      div_in  = div_ff;
      r_in    = r_ff;
      trial   = {r_ff, sh_ff[LFSR_W-1]};
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         sh_in   = dividend;
         div_in  = divisor;
         r_in    = '0;
      end else if (run_ff) begin
         // restoring step: remainder stays below the divisor
         if (trial >= {1'b0, div_ff}) begin
            r_in = COUNT_W'(trial - {1'b0, div_ff});
         end else begin
            r_in = COUNT_W'(trial);
         end
         sh_in   = {sh_ff[LFSR_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(LFSR_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      sh_ff   <= sh_in;
      div_ff  <= div_in;
      r_ff    <= r_in;
   end

   assign done = done_ff;
   assign rem  = r_ff;

endmodule

@@ tb/per_layer_quota_handle_cache_tb.sv @@
// Testbench for per_layer_quota_handle_cache: directed and random lookup/erase/clear
// commands checked against a behavioral model of the cache. Depends on plqhc_pkg and the RTL.
`timescale 1ns / 1ps
module per_layer_quota_handle_cache_tb;
   import plqhc_pkg::*;

   localparam int ENTRIES = 64;
   localparam int LAYERS  = 8;
   localparam int CYCLE_LIMIT = 20000000;
   localparam logic [1:0] KIND_NONE = 2'd3;

   typedef struct {
      logic [1:0]          kind;
      logic [STAMP_W-1:0]  stamp;
      logic [LAYER_W-1:0]  layer;
      logic [HANDLE_W-1:0] fresh;
      logic                ok;
   } cmd_type;

   typedef struct {
      logic                rkind;
      logic [HANDLE_W-1:0] handle;
      logic                hit;
      logic                last;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_kind = '0;
   logic [STAMP_W-1:0] req_stamp = '0;
   logic [LAYER_W-1:0] req_layer = '0;
   logic [HANDLE_W-1:0] req_fresh_handle = '0;
   logic req_fresh_ok = 1'b0;
   logic rsp_valid, rsp_result_kind, rsp_hit, rsp_last;
   logic [HANDLE_W-1:0] rsp_handle;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   per_layer_quota_handle_cache #(.ENTRIES(ENTRIES), .LAYERS(LAYERS)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // cache model
   logic [LIMIT_W-1:0]  m_limit;
   logic                m_valid [ENTRIES];
   logic [STAMP_W-1:0]  m_stamp [ENTRIES];
   logic [LAYER_W-1:0]  m_layer [ENTRIES];
   logic [HANDLE_W-1:0] m_handle [ENTRIES];
   logic [COUNT_W-1:0]  m_count [LAYERS];
   logic [LFSR_W-1:0]   m_lfsr;

   cmd_type    pending_cmds[$];
   answer_type expected_answers[$];
   int      errors = 0;
   int      sent = 0;
   bit      driving = 1'b1;
   bit      quiet = 1'b0;
   int      cycles = 0;

   function automatic int ranked_slot(bit all, logic [LAYER_W-1:0] ly, int rank);
      int below;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!m_valid[i] || (!all && m_layer[i] != ly)) continue;
         below = 0;
         for (int j = 0; j < ENTRIES; j++)
            if (m_valid[j] && (all || m_layer[j] == ly) && m_stamp[j] < m_stamp[i])
               below++;
         if (below == rank) return i;
      end
      return -1;
   endfunction

   function automatic void push_answer(ref int n, input logic rk, input logic [31:0] h,
                                       input logic ht);
      answer_type a;
      if (n >= MAX_RESULTS) return;
      a.rkind = rk; a.handle = h; a.hit = ht; a.last = 1'b0;
      expected_answers.insert(expected_answers.size(), a);
      n++;
   endfunction

   function automatic void add_cmd(cmd_type c);
      pending_cmds.insert(pending_cmds.size(), c);
   endfunction

   function automatic void predict_cache(cmd_type c);
      int n, lim, v, r, s;
      logic fb;
      n = 0;
      lim = (m_limit == 0) ? 1 : m_limit;
      if (c.kind == KIND_LOOKUP) begin
         for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && m_stamp[i] == c.stamp) begin
               push_answer(n, RES_ANSWER, m_handle[i], 1'b1);
               expected_answers[$].last = 1'b1;
               return;
            end
         if (c.ok) begin
            while (m_count[c.layer] >= lim) begin
               fb = m_lfsr[0] ^ m_lfsr[2] ^ m_lfsr[3] ^ m_lfsr[5];
               m_lfsr = {fb, m_lfsr[15:1]};
               v = ranked_slot(1'b0, c.layer, int'(m_lfsr) % int'(m_count[c.layer]));
               if (v < 0) break;
               push_answer(n, RES_CLOSE, m_handle[v], 1'b0);
               m_valid[v] = 1'b0;
               m_count[c.layer]--;
            end
            for (int i = 0; i < ENTRIES; i++)
               if (!m_valid[i]) begin
                  m_valid[i] = 1'b1; m_stamp[i] = c.stamp;
                  m_layer[i] = c.layer; m_handle[i] = c.fresh;
                  m_count[c.layer]++;
                  break;
               end
         end
         // answer always goes out, even past the report cap
         if (n >= MAX_RESULTS) begin
            void'(expected_answers.pop_back());
            n--;
         end
         push_answer(n, RES_ANSWER, c.ok ? c.fresh : '0, 1'b0);
         expected_answers[$].last = 1'b1;
      end else if (c.kind == KIND_ERASE || c.kind == KIND_CLEAR) begin
         r = 0;
         forever begin
            s = ranked_slot(c.kind == KIND_CLEAR, c.layer, r);
            if (s < 0) break;
            push_answer(n, RES_CLOSE, m_handle[s], 1'b0);
            r++;
         end
         for (int i = 0; i < ENTRIES; i++)
            if (m_valid[i] && (c.kind == KIND_CLEAR || m_layer[i] == c.layer))
               m_valid[i] = 1'b0;
         if (c.kind == KIND_CLEAR) for (int l = 0; l < LAYERS; l++) m_count[l] = '0;
         else m_count[c.layer] = '0;
         if (n > 0) expected_answers[$].last = 1'b1;
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin : drive_blk
      cmd_type acc;
      cmd_type nxt;
      cycles <= cycles + 1;
      if (!reset) begin
         if (start && !busy) begin
            acc.kind  = req_kind;
            acc.stamp = req_stamp;
            acc.layer = req_layer;
            acc.fresh = req_fresh_handle;
            acc.ok    = req_fresh_ok;
            predict_cache(acc);
            sent <= sent + 1;
         end
         if (!(start && busy)) begin
            if (driving && pending_cmds.size() > 0 &&
                (quiet || $urandom_range(99) >= 20)) begin
               nxt = pending_cmds.pop_front();
               start <= 1'b1;
               req_kind <= nxt.kind; req_stamp <= nxt.stamp; req_layer <= nxt.layer;
               req_fresh_handle <= nxt.fresh; req_fresh_ok <= nxt.ok;
            end else
               start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin : mon_blk
      answer_type e;
      if (!reset && rsp_valid) begin
         if (expected_answers.size() == 0)
            report_mismatch("unexpected transfer", 64'(rsp_handle), 64'd0);
         else begin
            e = expected_answers.pop_front();
            if (rsp_result_kind !== e.rkind)
               report_mismatch("result_kind", 64'(rsp_result_kind), 64'(e.rkind));
            if (rsp_handle !== e.handle)
               report_mismatch("handle", 64'(rsp_handle), 64'(e.handle));
            if (rsp_hit !== e.hit) report_mismatch("hit", 64'(rsp_hit), 64'(e.hit));
            if (rsp_last !== e.last) report_mismatch("last", 64'(rsp_last), 64'(e.last));
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_write(logic [3:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      m_limit = value;
   endtask

   // push items and wait until all are taken and answered
   task automatic run_batch();
      driving = 1'b1;
      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (start || busy || expected_answers.size() > 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic cmd_type rand_cmd(int stamp_pool);
      cmd_type c;
      int p;
      p = $urandom_range(99);
      c.kind  = (p < 80) ? KIND_LOOKUP : (p < 90) ? KIND_ERASE : (p < 95) ? KIND_CLEAR :
                KIND_NONE;
      c.stamp = (stamp_pool > 0) ? 64'($urandom_range(stamp_pool - 1)) << 61 |
                64'($urandom_range(stamp_pool - 1))
                : {$urandom, $urandom};
      c.layer = $urandom_range(7) < 5 ? 3'($urandom_range(2)) : 3'($urandom);
      c.fresh = $urandom;
      c.ok    = $urandom_range(9) != 0;
      return c;
   endfunction

   initial begin
      cmd_type c;
      for (int i = 0; i < ENTRIES; i++) m_valid[i] = 1'b0;
      for (int l = 0; l < LAYERS; l++) m_count[l] = '0;
      m_lfsr = LFSR_SEED;
      m_limit = LIMIT_RESET;
      driving = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, hits, misses, failed miss, eviction, erase, clear, unknown
      add_cmd('{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF, 1'b1});
      add_cmd('{KIND_LOOKUP, 64'h0, 3'd0, 32'h0, 1'b1});
      add_cmd('{KIND_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 32'h1234, 1'b1});
      add_cmd('{KIND_LOOKUP, 64'h55, 3'd2, 32'hAAAA_5555, 1'b0});
      for (int i = 1; i <= 6; i++)
         add_cmd('{KIND_LOOKUP, 64'(i * 7), 3'd1, 32'(i), 1'b1});
      add_cmd('{KIND_ERASE, 64'h0, 3'd4, 32'h0, 1'b0});
      add_cmd('{KIND_ERASE, 64'h0, 3'd1, 32'h0, 1'b0});
      add_cmd('{KIND_NONE, 64'h0, 3'd0, 32'h0, 1'b1});
      add_cmd('{KIND_CLEAR, 64'h0, 3'd0, 32'h0, 1'b0});
      add_cmd('{KIND_CLEAR, 64'h0, 3'd0, 32'h0, 1'b0});
      run_batch();
      // phases over limits, extremes included; store filled past 64 in the 15 phase
      for (int ph = 0; ph < 5; ph++) begin
         logic [3:0] lim;
         int n;
         lim = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd0 : (ph == 2) ? 4'd15 :
               (ph == 3) ? 4'd8 : 4'($urandom_range(2, 7));
         csr_write(lim);
         n = (ph == 2) ? 70 : 22;
         quiet = (ph == 3);
         for (int i = 0; i < n; i++) begin
            c = rand_cmd(ph == 2 ? 0 : 12);
            if (ph == 2) begin
               c.layer = 3'(i % 8); c.kind = KIND_LOOKUP; c.ok = 1'b1;
            end
            // drop the full store in one go
            if (ph == 3 && i == 0) c.kind = KIND_CLEAR;
            add_cmd(c);
         end
         run_batch();
      end
      quiet = 1'b0;
      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
